// ----- rtl/pfn_pkg.sv -----
// Package for the pillar feature net layer: operation codes, widths and shared types.
// No dependencies.
`default_nettype none
package pfn_pkg;
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] OP_LOAD_SCALE  = 2'd1;
  localparam logic [1:0] OP_LOAD_OFFSET = 2'd2;
  localparam logic [1:0] OP_FEATURE     = 2'd3;

  localparam int unsigned AccW = 40;
  localparam int unsigned MaxW = 15;
  localparam logic [MaxW-1:0] MaxOut = 15'h7fff;

  typedef struct packed {
    logic        mac;       // add feature * weight
    logic        finish;    // end of point
    logic        keep;      // point had a nonzero feature
    logic        wr_weight;
    logic        wr_scale;
    logic        wr_offset;
    logic [3:0]  fidx;
    logic [15:0] value;
  } cell_ctrl_t;
endpackage
`default_nettype wire

// ----- rtl/pillar_feature_net_layer_core.sv -----
// Pillar feature net layer top level: input decode, row of channel cells, output drain.
// Depends on pfn_pkg and pfn_cell.
// Usage: load transfers (operation 0..2) write the weight, scale and offset tables;
// point feature transfers (operation 3) stream one feature each, and tlast marks
// the pillar's final feature. Each cell does one multiply-accumulate per feature.
// A point end (last_feature or tlast) adds a pooling step after the final feature,
// in which each accumulator is scaled, offset, clamped and, if the point had a
// nonzero feature, folded into the maximum; input is held off during that step.
// At a pillar end the maxima shift out of the cell chain one channel per cycle
// while the receiver takes them, through the output register; the first result
// follows the pooling step and the drain register, and input stays blocked until
// the last result is taken.
// Reset clears accumulators, maxima and control; tables are undefined until
// loaded. When the receiver stalls, the drain holds and input stays blocked.
// Config: APB, register 0 feature_count at 0x0, register 1 channel_count at 0x4.
`default_nettype none
module pillar_feature_net_layer_core
  import pfn_pkg::*;
#(
  parameter int unsigned NumChannels = 64,
  parameter int unsigned NumFeatures = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // channel[5:0], feature_index[9:6], value[25:10], zero pad
  input  wire  [31:0] s_axis_tdata,
  // operation[1:0], last_feature[2]
  input  wire  [2:0]  s_axis_tuser,
  input  wire         s_axis_tlast,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // out_channel[5:0], pooled_feature[20:6], zero pad
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic [0:0] RegFeat = 1'd0;
  localparam logic [0:0] RegChan = 1'd1;

  logic [4:0] fcount_q;
  logic [6:0] ccount_q;
  logic [6:0] nact;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q <= 5'd10;
      ccount_q <= 7'd64;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == RegFeat) begin
      fcount_q <= pwdata[4:0];
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == RegChan) begin
      ccount_q <= pwdata[6:0];
    end
  end
  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      RegFeat: prdata = {27'd0, fcount_q};
      RegChan: prdata = {25'd0, ccount_q};
      default: prdata = '0;
    endcase
  end
  assign nact = (ccount_q == 7'd0) ? 7'd1 :
                (ccount_q > 7'(NumChannels)) ? 7'(NumChannels) : ccount_q;

  logic [1:0]  op;
  logic [5:0]  ch;
  logic [3:0]  fi;
  logic [15:0] val;
  logic        lf, lp, acc_in, fvalid, fin;
  logic        nz_q, nz_d;
  logic        pool_q, keep_q, lastp_q;
  cell_ctrl_t  ctrl;

  assign op  = s_axis_tuser[1:0];
  assign ch  = s_axis_tdata[5:0];
  assign fi  = s_axis_tdata[9:6];
  assign val = s_axis_tdata[25:10];
  assign lf  = s_axis_tuser[2];
  assign lp  = s_axis_tlast;

  logic       drain_q;
  logic [6:0] left_q;
  logic [5:0] och_q;
  logic       shift;

  assign s_axis_tready = !drain_q && !pool_q && !m_axis_tvalid;
  assign acc_in = s_axis_tvalid && s_axis_tready;
  assign fvalid = (op == OP_FEATURE) && ({1'b0, fi} < fcount_q)
                  && (32'(fi) < NumFeatures);
  assign fin = acc_in && (op == OP_FEATURE) && (lf || lp);

  always_comb begin
    ctrl.mac       = acc_in && fvalid;
    ctrl.finish    = pool_q;
    ctrl.keep      = keep_q;
    ctrl.wr_weight = acc_in && op == OP_LOAD_WEIGHT && 32'(fi) < NumFeatures;
    ctrl.wr_scale  = acc_in && op == OP_LOAD_SCALE;
    ctrl.wr_offset = acc_in && op == OP_LOAD_OFFSET;
    ctrl.fidx      = fi;
    ctrl.value     = val;
    nz_d = nz_q || (ctrl.mac && val != 16'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q <= 1'b0;
      pool_q <= 1'b0;
      keep_q <= 1'b0;
      lastp_q <= 1'b0;
    end else begin
      pool_q <= fin;
      if (fin) begin
        nz_q <= 1'b0;
        keep_q <= nz_d;
        lastp_q <= lp;
      end else begin
        nz_q <= nz_d;
      end
    end
  end

  logic [MaxW-1:0] chain [NumChannels+1];
  assign chain[NumChannels] = '0;
  assign shift = drain_q && (!m_axis_tvalid || m_axis_tready);

  for (genvar c = 0; c < NumChannels; c++) begin : g_cell
    pfn_cell #(.InChannels(NumFeatures)) u_cell (
      .clk_i, .rst_ni,
      .ctrl_i  (ctrl),
      .sel_i   (32'(ch) == c),
      .active_i(7'(c) < nact),
      .shift_i (shift),
      .max_i   (chain[c+1]),
      .max_o   (chain[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      left_q <= '0;
      och_q <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata <= '0;
      m_axis_tlast <= 1'b0;
    end else begin
      if (pool_q && lastp_q) begin
        drain_q <= 1'b1;
        left_q <= nact;
        och_q <= '0;
      end else if (shift) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= {3'd0, chain[0], och_q};
        m_axis_tlast <= (left_q == 7'd1);
        och_q <= och_q + 6'd1;
        left_q <= left_q - 7'd1;
        if (left_q == 7'd1) drain_q <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  logic unused;
  assign unused = ^s_axis_tdata[31:26];

`ifndef NO_ASSERTIONS
  a_no_accept_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> !s_axis_tready) else $error("input accepted during drain");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |-> !drain_q)
    else $error("drain continues after last channel");
  a_left_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (left_q != 7'd0)) else $error("drain with nothing left");
  a_pool_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_q |-> !s_axis_tready) else $error("input accepted during pooling");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output changed while stalled");
`endif
endmodule
`default_nettype wire

// ----- rtl/pfn_cell.sv -----
// One output channel cell: weight row, scale, offset, accumulator, running maximum.
// Depends on pfn_pkg. Hands its maximum to the neighbour on shift.
`default_nettype none
module pfn_cell
  import pfn_pkg::*;
#(
  parameter int unsigned InChannels = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire cell_ctrl_t  ctrl_i,
  input  wire              sel_i,
  input  wire              active_i,
  input  wire              shift_i,
  input  wire  [MaxW-1:0]  max_i,
  output logic [MaxW-1:0]  max_o
);
  localparam int unsigned FiW = (InChannels > 1) ? $clog2(InChannels) : 1;

  logic signed [15:0] weight_q [InChannels];
  logic signed [15:0] scale_q, offset_q;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [MaxW-1:0]    max_q, max_d;
  logic signed [15:0] w_sel;
  logic signed [31:0] prod;
  logic signed [55:0] sprod;
  logic signed [30:0] act;
  logic [MaxW-1:0]    act_sat;
  logic [FiW-1:0]     fi;

  assign fi = ctrl_i.fidx[FiW-1:0];
  assign w_sel = weight_q[fi];
  assign prod = $signed(ctrl_i.value) * w_sel;

  always_ff @(posedge clk_i) begin
    if (sel_i && ctrl_i.wr_weight) weight_q[fi] <= ctrl_i.value;
    if (sel_i && ctrl_i.wr_scale) scale_q <= ctrl_i.value;
    if (sel_i && ctrl_i.wr_offset) offset_q <= ctrl_i.value;
  end

  always_comb begin
    sprod = $signed(acc_q) * scale_q;
    act = 31'(((sprod + 56'sd33554432) >>> 26)) + 31'(offset_q);
    if (act < 0) act_sat = '0;
    else if (act > 31'sd32767) act_sat = MaxOut;
    else act_sat = act[MaxW-1:0];
  end

  always_comb begin
    acc_d = acc_q;
    max_d = max_q;
    if (ctrl_i.mac && active_i) acc_d = acc_q + AccW'(prod);
    if (ctrl_i.finish) begin
      acc_d = '0;
      if (ctrl_i.keep && active_i && act_sat > max_q) max_d = act_sat;
    end
    if (shift_i) max_d = max_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      max_q <= '0;
    end else begin
      acc_q <= acc_d;
      max_q <= max_d;
    end
  end

  assign max_o = max_q;
endmodule
`default_nettype wire
